// ----- rtl/cvf_pkg.sv -----
package cvf_pkg;

  localparam int PIX_BITS     = 8;
  localparam int CHANNELS     = 3;
  localparam int WIN          = 3;
  localparam int CENTER_TAP   = 4;
  localparam int MIN_SIZE     = 3;
  localparam int FW_BITS      = 11;
  localparam int FH_BITS      = 16;
  localparam int CFG_IDX_BITS = 2;
  localparam int RESET_WIDTH  = 1024;
  localparam int RESET_HEIGHT = 1024;

  typedef logic [CHANNELS*PIX_BITS-1:0] pixel_t;

  typedef struct packed {
    pixel_t top;
    pixel_t mid;
    pixel_t bot;
  } col_t;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_FRAME_WIDTH   = 2'd0,
    REG_FRAME_HEIGHT  = 2'd1,
    REG_KERNEL_COEFFS = 2'd2
  } cfg_reg_t;

endpackage

// ----- rtl/cvf_line_store.sv -----
module cvf_line_store #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 24
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/cvf_cell.sv -----
module cvf_cell #(
  parameter int COEF_BITS = 5
) (
  input  logic                                                clk,
  input  logic                                                shift,
  input  logic                                                cap,
  input  logic [3*COEF_BITS-1:0]                              coefs,
  input  cvf_pkg::col_t                                       col_in,
  output cvf_pkg::col_t                                       col_q,
  output logic signed [cvf_pkg::PIX_BITS+COEF_BITS+1:0]       part [cvf_pkg::CHANNELS]
);

  import cvf_pkg::*;

  localparam int PW = PIX_BITS + COEF_BITS + 2;

  pixel_t               rows      [WIN];
  logic signed [PW-1:0] part_next [CHANNELS];

  always_comb begin
    rows[0] = col_q.top;
    rows[1] = col_q.mid;
    rows[2] = col_q.bot;
  end

  always_comb begin
    logic signed [PW-1:0] acc;
    acc = '0;
    for (int ch = 0; ch < CHANNELS; ch++) begin
      acc = '0;
      for (int b = 0; b < WIN; b++) begin
        acc = acc + PW'($signed({1'b0, rows[b][PIX_BITS*ch +: PIX_BITS]}))
                  * PW'($signed(coefs[COEF_BITS*b +: COEF_BITS]));
      end
      part_next[ch] = acc;
    end
  end

  always_ff @(posedge clk) begin
    if (shift) begin
      col_q <= col_in;
    end
    if (cap) begin
      part <= part_next;
    end
  end

endmodule

// ----- rtl/conv3x3_clamped_pixel_filter_unit.sv -----
// 3x3 convolution over a raster-order RGB pixel stream, one word per clock
// while the output is not stalled. A word is registered in stage one, the
// column cells and the output register; its result belongs to the pixel one
// line plus one pixel behind, so each frame is followed by width+1 padding
// words. The two line stores each do one write and one read per clock, and
// the chain of three column cells takes one column per clock, which together
// set the rate of one pixel per clock. Line stores need no clearing pass
// after reset: a fill mark makes never-written entries read as zero. Border
// pixels pass through unchanged, interior pixels are the clamped kernel sum.
module conv3x3_clamped_pixel_filter_unit #(
  parameter int MAX_WIDTH = 1024,
  parameter int COEF_BITS = 5
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [cvf_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  logic [9*COEF_BITS-1:0]             cfg_data,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [cvf_pkg::PIX_BITS-1:0]       red_in,
  input  logic [cvf_pkg::PIX_BITS-1:0]       green_in,
  input  logic [cvf_pkg::PIX_BITS-1:0]       blue_in,
  input  logic                               is_padding,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [cvf_pkg::PIX_BITS-1:0]       red_out,
  output logic [cvf_pkg::PIX_BITS-1:0]       green_out,
  output logic [cvf_pkg::PIX_BITS-1:0]       blue_out,
  output logic                               frame_end
);

  import cvf_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int XW = (WW > FW_BITS) ? WW : FW_BITS;
  localparam int KB = WIN * WIN * COEF_BITS;
  localparam int PW = PIX_BITS + COEF_BITS + 2;
  localparam int SW = PW + 2;

  typedef struct packed {
    logic border;
    logic last;
  } ctl_t;

  logic [FW_BITS-1:0] frame_width;
  logic [FH_BITS-1:0] frame_height;
  logic [KB-1:0]      kernel_coeffs;

  logic [CW-1:0]      in_column;
  logic [FH_BITS-1:0] in_row;
  logic [WW-1:0]      fill;

  logic               advance;
  logic               accept;
  pixel_t             pix;

  logic [XW-1:0]      fw_x;
  logic [WW-1:0]      w_eff;
  logic [FH_BITS-1:0] h_eff;
  logic [WW-1:0]      col_ext;
  logic [WW-1:0]      col_inc;
  logic               col_nz;
  logic               res_ok;
  logic [FH_BITS-1:0] rout;
  logic [WW-1:0]      cout;
  logic               row_edge;
  logic               col_edge;
  logic               line_end;
  ctl_t               ctl;

  logic               s1_item;
  logic               s1_res;
  ctl_t               s1_ctl;
  pixel_t             s1_pix;
  logic [CW-1:0]      s1_idx;
  logic               s1_ok;
  logic               s1_fwd;
  pixel_t             s1_fwd_data;

  pixel_t             up_rd;
  pixel_t             lo_rd;
  pixel_t             top;
  pixel_t             mid;
  col_t               new_col;

  col_t               col_in [WIN];
  col_t               col_q  [WIN];
  logic signed [PW-1:0] part [WIN][CHANNELS];

  logic               s2_res;
  ctl_t               s2_ctl;
  logic               s3_res;
  ctl_t               s3_ctl;
  pixel_t             s3_center;

  logic signed [SW-1:0] sums [CHANNELS];
  pixel_t             filt;
  pixel_t             res_pix;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width   <= FW_BITS'(RESET_WIDTH);
      frame_height  <= FH_BITS'(RESET_HEIGHT);
      kernel_coeffs <= KB'(1) << (CENTER_TAP * COEF_BITS);
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_FRAME_WIDTH: begin
          frame_width <= cfg_data[FW_BITS-1:0];
        end
        REG_FRAME_HEIGHT: begin
          frame_height <= cfg_data[FH_BITS-1:0];
        end
        REG_KERNEL_COEFFS: begin
          kernel_coeffs <= cfg_data[KB-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  assign advance  = !out_valid || !out_stall;
  assign in_stall = !advance;
  assign accept   = in_valid && advance;
  assign pix      = is_padding ? '0 : {blue_in, green_in, red_in};

  always_comb begin
    fw_x = XW'(frame_width);
    if (fw_x < XW'(MIN_SIZE)) begin
      w_eff = WW'(MIN_SIZE);
    end else if (fw_x > XW'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(fw_x);
    end
    h_eff = (frame_height < FH_BITS'(MIN_SIZE)) ? FH_BITS'(MIN_SIZE) : frame_height;

    col_ext  = WW'(in_column);
    col_inc  = col_ext + WW'(1);
    col_nz   = in_column != '0;
    res_ok   = col_nz ? (in_row != '0) : (in_row >= FH_BITS'(2));
    rout     = col_nz ? in_row - FH_BITS'(1) : in_row - FH_BITS'(2);
    cout     = col_nz ? col_ext - WW'(1) : w_eff - WW'(1);
    row_edge = rout >= h_eff - FH_BITS'(1);
    col_edge = cout >= w_eff - WW'(1);
    ctl.border = (rout == '0) || (cout == '0) || row_edge || col_edge;
    ctl.last   = row_edge && col_edge;
    line_end = col_inc >= w_eff;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_column <= '0;
      in_row    <= '0;
      fill      <= '0;
    end else if (accept) begin
      if (res_ok && ctl.last) begin
        in_column <= '0;
        in_row    <= '0;
      end else if (line_end) begin
        in_column <= '0;
        in_row    <= in_row + FH_BITS'(1);
      end else begin
        in_column <= col_inc[CW-1:0];
      end
      if (col_inc > fill) begin
        fill <= col_inc;
      end
    end
  end

  // The upper store is written in the cycle after the read, so a back-to-back
  // item at the same column takes the pending value from stage one.
  assign mid     = s1_ok ? lo_rd : '0;
  assign top     = s1_fwd ? s1_fwd_data : (s1_ok ? up_rd : '0);
  assign new_col = '{top: top, mid: mid, bot: s1_pix};

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_item <= 1'b0;
      s1_res  <= 1'b0;
    end else if (advance) begin
      s1_item <= accept;
      s1_res  <= accept && res_ok;
    end
    if (accept) begin
      s1_ctl      <= ctl;
      s1_pix      <= pix;
      s1_idx      <= in_column;
      s1_ok       <= col_ext < fill;
      s1_fwd      <= s1_item && (s1_idx == in_column);
      s1_fwd_data <= mid;
    end
  end

  cvf_line_store #(
    .DEPTH (MAX_WIDTH),
    .WIDTH ($bits(pixel_t))
  ) u_store_upper (
    .clk   (clk),
    .we    (s1_item),
    .waddr (s1_idx),
    .wdata (mid),
    .re    (accept),
    .raddr (in_column),
    .rdata (up_rd)
  );

  cvf_line_store #(
    .DEPTH (MAX_WIDTH),
    .WIDTH ($bits(pixel_t))
  ) u_store_lower (
    .clk   (clk),
    .we    (accept),
    .waddr (in_column),
    .wdata (pix),
    .re    (accept),
    .raddr (in_column),
    .rdata (lo_rd)
  );

  assign col_in[WIN-1] = new_col;

  for (genvar a = 0; a < WIN; a++) begin : g_cell
    if (a < WIN - 1) begin : g_link
      assign col_in[a] = col_q[a+1];
    end
    cvf_cell #(
      .COEF_BITS (COEF_BITS)
    ) u_cell (
      .clk    (clk),
      .shift  (advance && s1_item),
      .cap    (advance),
      .coefs  (kernel_coeffs[WIN*a*COEF_BITS +: WIN*COEF_BITS]),
      .col_in (col_in[a]),
      .col_q  (col_q[a]),
      .part   (part[a])
    );
  end

  always_comb begin
    for (int ch = 0; ch < CHANNELS; ch++) begin
      sums[ch] = SW'(part[0][ch]) + SW'(part[1][ch]) + SW'(part[2][ch]);
      if (sums[ch][SW-1]) begin
        filt[PIX_BITS*ch +: PIX_BITS] = '0;
      end else if (|sums[ch][SW-2:PIX_BITS]) begin
        filt[PIX_BITS*ch +: PIX_BITS] = '1;
      end else begin
        filt[PIX_BITS*ch +: PIX_BITS] = sums[ch][PIX_BITS-1:0];
      end
    end
    res_pix = s3_ctl.border ? s3_center : filt;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_res    <= 1'b0;
      s3_res    <= 1'b0;
      out_valid <= 1'b0;
    end else if (advance) begin
      s2_res    <= s1_res;
      s3_res    <= s2_res;
      out_valid <= s3_res;
    end
    if (advance) begin
      s2_ctl    <= s1_ctl;
      s3_ctl    <= s2_ctl;
      s3_center <= col_q[1].mid;
      red_out   <= res_pix[0 +: PIX_BITS];
      green_out <= res_pix[PIX_BITS +: PIX_BITS];
      blue_out  <= res_pix[2*PIX_BITS +: PIX_BITS];
      frame_end <= s3_ctl.last;
    end
  end

endmodule

// ----- rtl/cvf_checker.sv -----
module cvf_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] red_out,
  input logic [7:0] green_out,
  input logic [7:0] blue_out,
  input logic       frame_end
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("Output word dropped while stalled.");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(red_out) && $stable(green_out)
                             && $stable(blue_out) && $stable(frame_end))
    else $error("Output word changed while stalled.");

  // The input side stalls exactly when a finished word is held back.
  a_in_stall: assert property (@(posedge clk)
    in_stall == (out_valid && out_stall))
    else $error("Input stall does not follow the output register.");

  a_reset: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("Output word present right after reset.");

endmodule

bind conv3x3_clamped_pixel_filter_unit cvf_checker u_cvf_checker (.*);

// ----- tb/conv3x3_filter_checker.sv -----
module conv3x3_filter_checker
  import cvf_pkg::*;
#(
  parameter int MAX_WIDTH = 1024,
  parameter int COEF_BITS = 5
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_valid,
  input  logic                      cfg_ready,
  input  logic [CFG_IDX_BITS-1:0]   cfg_index,
  input  logic [9*COEF_BITS-1:0]    cfg_data,
  input  logic                      in_valid,
  input  logic                      in_stall,
  input  logic [PIX_BITS-1:0]       red_in,
  input  logic [PIX_BITS-1:0]       green_in,
  input  logic [PIX_BITS-1:0]       blue_in,
  input  logic                      is_padding,
  input  logic                      out_valid,
  input  logic                      out_stall,
  input  logic [PIX_BITS-1:0]       red_out,
  input  logic [PIX_BITS-1:0]       green_out,
  input  logic [PIX_BITS-1:0]       blue_out,
  input  logic                      frame_end,
  output int                        errors,
  output int                        pending,
  output int                        frames_done
);

  typedef struct packed {
    logic [PIX_BITS-1:0] red;
    logic [PIX_BITS-1:0] green;
    logic [PIX_BITS-1:0] blue;
    logic                last;
  } filtered_px_t;

  logic [FW_BITS-1:0]     width_reg;
  logic [FH_BITS-1:0]     height_reg;
  logic [9*COEF_BITS-1:0] kernel_reg;
  pixel_t                 line_upper [MAX_WIDTH];
  pixel_t                 line_lower [MAX_WIDTH];
  pixel_t                 window [WIN][WIN];
  int                     column;
  logic [FH_BITS-1:0]     row;
  filtered_px_t           expected_px [$];

  initial errors = 0;

  function automatic logic [PIX_BITS-1:0] weighted_channel(input int shift);
    int acc;
    int coef;
    logic signed [COEF_BITS-1:0] raw;
    acc = 0;
    for (int a = 0; a < WIN; a++) begin
      for (int b = 0; b < WIN; b++) begin
        raw = kernel_reg[COEF_BITS*(WIN*a+b) +: COEF_BITS];
        coef = raw;
        acc += int'(window[a][b][shift +: PIX_BITS]) * coef;
      end
    end
    if (acc > 255) return 8'hff;
    if (acc < 0) return 8'h00;
    return acc[PIX_BITS-1:0];
  endfunction

  // One accepted word shifts the window by one column and may release the
  // pixel one line plus one pixel behind it.
  task automatic advance_window(input pixel_t pix);
    int w;
    int h;
    int idx;
    int rout;
    int cout;
    logic ok;
    logic on_border;
    logic last;
    pixel_t top_px;
    pixel_t mid_px;
    filtered_px_t res;
    w = width_reg;
    if (w < MIN_SIZE) w = MIN_SIZE;
    if (w > MAX_WIDTH) w = MAX_WIDTH;
    h = height_reg;
    if (h < MIN_SIZE) h = MIN_SIZE;
    idx = (column < MAX_WIDTH) ? column : MAX_WIDTH - 1;
    top_px = line_upper[idx];
    mid_px = line_lower[idx];
    line_upper[idx] = mid_px;
    line_lower[idx] = pix;
    for (int b = 0; b < WIN; b++) begin
      window[0][b] = window[1][b];
      window[1][b] = window[2][b];
    end
    window[2][0] = top_px;
    window[2][1] = mid_px;
    window[2][2] = pix;
    if (column >= 1) begin
      ok = (row >= 1);
      rout = int'(row) - 1;
      cout = column - 1;
    end else begin
      ok = (row >= 2);
      rout = int'(row) - 2;
      cout = w - 1;
    end
    column++;
    if (column >= w) begin
      column = 0;
      row = row + 1'b1;
    end
    if (ok) begin
      on_border = rout == 0 || cout == 0 || rout >= h - 1 || cout >= w - 1;
      last = rout >= h - 1 && cout >= w - 1;
      if (on_border) begin
        res.red = window[1][1][0 +: PIX_BITS];
        res.green = window[1][1][PIX_BITS +: PIX_BITS];
        res.blue = window[1][1][2*PIX_BITS +: PIX_BITS];
      end else begin
        res.red = weighted_channel(0);
        res.green = weighted_channel(PIX_BITS);
        res.blue = weighted_channel(2*PIX_BITS);
      end
      res.last = last;
      expected_px.push_back(res);
      if (last) begin
        column = 0;
        row = '0;
        frames_done <= frames_done + 1;
      end
    end
  endtask

  task automatic log_failure(input string what, input filtered_px_t want,
                             input filtered_px_t got);
    errors++;
    if (errors <= 10) begin
      $display("%0t: %s: expected r=%0d g=%0d b=%0d end=%0b, got r=%0d g=%0d b=%0d end=%0b",
               $time, what, want.red, want.green, want.blue, want.last,
               got.red, got.green, got.blue, got.last);
    end
  endtask

  always @(posedge clk) begin
    filtered_px_t got;
    filtered_px_t want;
    if (rst) begin
      width_reg = RESET_WIDTH;
      height_reg = RESET_HEIGHT;
      kernel_reg = {{(9*COEF_BITS-1){1'b0}}, 1'b1} << (COEF_BITS*CENTER_TAP);
      for (int i = 0; i < MAX_WIDTH; i++) begin
        line_upper[i] = '0;
        line_lower[i] = '0;
      end
      for (int a = 0; a < WIN; a++) begin
        for (int b = 0; b < WIN; b++) begin
          window[a][b] = '0;
        end
      end
      column = 0;
      row = '0;
      expected_px.delete();
      frames_done <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_FRAME_WIDTH: width_reg = cfg_data[FW_BITS-1:0];
          REG_FRAME_HEIGHT: height_reg = cfg_data[FH_BITS-1:0];
          REG_KERNEL_COEFFS: kernel_reg = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        advance_window(is_padding ? pixel_t'(0) : {blue_in, green_in, red_in});
      end
      if (out_valid && !out_stall) begin
        got = '{red_out, green_out, blue_out, frame_end};
        if (expected_px.size() == 0) begin
          log_failure("word with no prediction waiting", '0, got);
        end else begin
          want = expected_px.pop_front();
          if (got.red !== want.red || got.green !== want.green ||
              got.blue !== want.blue || got.last !== want.last) begin
            log_failure("output word mismatch", want, got);
          end
        end
      end
    end
    pending <= expected_px.size();
  end

endmodule

// ----- tb/tb_conv3x3_clamped_pixel_filter_unit.sv -----
module tb_conv3x3_clamped_pixel_filter_unit;
  import cvf_pkg::*;

  localparam int MAX_W = 1024;
  localparam int CB = 5;
  localparam int KW = 9 * CB;
  localparam int SETTLE_CYCLES = 8;
  localparam int RANDOM_WORDS = 760;
  localparam logic [CFG_IDX_BITS-1:0] REG_UNUSED = 2'd3;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_BITS-1:0] cfg_index = '0;
  logic [KW-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [PIX_BITS-1:0] red_in = '0;
  logic [PIX_BITS-1:0] green_in = '0;
  logic [PIX_BITS-1:0] blue_in = '0;
  logic is_padding = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [PIX_BITS-1:0] red_out;
  logic [PIX_BITS-1:0] green_out;
  logic [PIX_BITS-1:0] blue_out;
  logic frame_end;

  int errors;
  int pending;
  int frames_done;
  int idle_pct = 0;
  int stall_pct = 0;
  int words_sent = 0;

  conv3x3_clamped_pixel_filter_unit #(.MAX_WIDTH(MAX_W), .COEF_BITS(CB)) u_top (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .red_in(red_in), .green_in(green_in), .blue_in(blue_in), .is_padding(is_padding),
    .out_valid(out_valid), .out_stall(out_stall),
    .red_out(red_out), .green_out(green_out), .blue_out(blue_out), .frame_end(frame_end)
  );

  conv3x3_filter_checker #(.MAX_WIDTH(MAX_W), .COEF_BITS(CB)) u_check (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .red_in(red_in), .green_in(green_in), .blue_in(blue_in), .is_padding(is_padding),
    .out_valid(out_valid), .out_stall(out_stall),
    .red_out(red_out), .green_out(green_out), .blue_out(blue_out), .frame_end(frame_end),
    .errors(errors), .pending(pending), .frames_done(frames_done)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #5000000;
    $display("tb_conv3x3_clamped_pixel_filter_unit NOT OK");
    $finish;
  end

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  function automatic logic [KW-1:0] pack_kernel(input int c [9]);
    logic [KW-1:0] k;
    k = '0;
    for (int i = 0; i < 9; i++) begin
      k[CB*i +: CB] = c[i][CB-1:0];
    end
    return k;
  endfunction

  function automatic logic [KW-1:0] pick_kernel();
    case ($urandom_range(7))
      0: return pack_kernel('{0, -1, 0, -1, 5, -1, 0, -1, 0});
      1: return pack_kernel('{1, 1, 1, 1, -8, 1, 1, 1, 1});
      2: return pack_kernel('{0, 1, 0, 1, -1, 1, 0, 1, 0});
      3: return {9{5'h0f}};
      4: return {9{5'h10}};
      5: return {9{5'h1f}};
      default: return KW'({$urandom, $urandom});
    endcase
  endfunction

  function automatic logic [PIX_BITS-1:0] pick_level();
    case ($urandom_range(3))
      0: return 8'h00;
      1: return 8'hff;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic set_idling(input int mode);
    case (mode)
      0: begin idle_pct = 0; stall_pct = 0; end
      1: begin idle_pct = 84; stall_pct = 0; end
      2: begin idle_pct = 0; stall_pct = 84; end
      default: begin idle_pct = 25; stall_pct = 25; end
    endcase
  endtask

  task automatic send_word(input logic [PIX_BITS-1:0] r, input logic [PIX_BITS-1:0] g,
                           input logic [PIX_BITS-1:0] b, input logic pad);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    red_in <= r;
    green_in <= g;
    blue_in <= b;
    is_padding <= pad;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    words_sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] index, input logic [KW-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic configure(input int w, input int h, input logic [KW-1:0] kernel);
    write_reg(REG_FRAME_WIDTH, KW'(w));
    write_reg(REG_FRAME_HEIGHT, KW'(h));
    write_reg(REG_KERNEL_COEFFS, kernel);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_frame(input int w_eff, input int h_eff, input int pause_at);
    for (int i = 0; i < w_eff * h_eff; i++) begin
      if (i == pause_at) drain();
      send_word(pick_level(), pick_level(), pick_level(), $urandom_range(49) == 0);
    end
    for (int i = 0; i <= w_eff; i++) begin
      send_word(8'($urandom), 8'($urandom), 8'($urandom), $urandom_range(9) != 0);
    end
  endtask

  task automatic flush_to_frame_end();
    int seen;
    seen = frames_done;
    while (frames_done == seen) begin
      send_word(8'($urandom), 8'($urandom), 8'($urandom), $urandom_range(3) != 0);
      in_valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  initial begin
    int frame_no;
    int wr;
    int hr;
    int w_eff;
    int h_eff;
    frame_no = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    configure(3, 3, pack_kernel('{0, -1, 0, -1, 5, -1, 0, -1, 0}));
    for (int i = 0; i < 9; i++) begin
      send_word(i[0] ? 8'hff : 8'h00, i[1] ? 8'hff : 8'h00,
                (i == 4) ? 8'hff : 8'($urandom), 1'b0);
    end
    for (int i = 0; i < 4; i++) begin
      send_word(8'hff, 8'hff, 8'hff, i != 2);
    end
    drain();
    configure(3, 3, pack_kernel('{1, 1, 1, 1, -8, 1, 1, 1, 1}));
    send_frame(3, 3, -1);
    drain();
    write_reg(REG_UNUSED, KW'({$urandom, $urandom}));
    cfg_valid <= 1'b0;

    // The frame size shrinks while a frame is half sent.
    set_idling(3);
    configure(1024, 65535, pick_kernel());
    repeat (50) send_word(pick_level(), pick_level(), pick_level(), 1'b0);
    drain();
    configure(5, 4, pack_kernel('{0, -1, 0, -1, 5, -1, 0, -1, 0}));
    flush_to_frame_end();
    drain();
    configure(8, 65535, pick_kernel());
    repeat (51) send_word(pick_level(), pick_level(), pick_level(), 1'b0);
    drain();
    configure(8, 4, pack_kernel('{0, 1, 0, 1, -1, 1, 0, 1, 0}));
    flush_to_frame_end();

    words_sent = 0;
    while (words_sent < RANDOM_WORDS) begin
      set_idling(frame_no % 4);
      wr = ($urandom_range(9) == 0) ? $urandom_range(2) : $urandom_range(3, 24);
      hr = ($urandom_range(9) == 0) ? $urandom_range(2) : $urandom_range(3, 8);
      w_eff = (wr < MIN_SIZE) ? MIN_SIZE : wr;
      h_eff = (hr < MIN_SIZE) ? MIN_SIZE : hr;
      drain();
      configure(wr, hr, pick_kernel());
      send_frame(w_eff, h_eff, (frame_no == 5) ? (w_eff * h_eff) / 2 : -1);
      frame_no++;
    end

    set_idling(0);
    drain();
    configure(2047, 65535, pick_kernel());
    repeat (MAX_W + 2) send_word(pick_level(), pick_level(), pick_level(), 1'b0);
    drain();
    configure(4, 3, pick_kernel());
    flush_to_frame_end();
    drain();

    if (errors == 0 && pending == 0) begin
      $display("tb_conv3x3_clamped_pixel_filter_unit OK");
    end else begin
      $display("tb_conv3x3_clamped_pixel_filter_unit NOT OK");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/cvf_pkg.sv
rtl/cvf_line_store.sv
rtl/cvf_cell.sv
rtl/conv3x3_clamped_pixel_filter_unit.sv
rtl/cvf_checker.sv
tb/conv3x3_filter_checker.sv
tb/tb_conv3x3_clamped_pixel_filter_unit.sv
